// ===== hw/rtl/decal_vertex_fade_color_macros.svh =====
// ----------------------------------------------------------------------------
// Decal vertex fade color assertion macros
// Shared concurrent assertion forms used by the decal vertex fade color block.
// ----------------------------------------------------------------------------
`ifndef DECAL_VERTEX_FADE_COLOR_MACROS_SVH
`define DECAL_VERTEX_FADE_COLOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DVFC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DVFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dvfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Decal vertex fade color package
// Register codes, reset values, pipeline stage numbers and carried types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dvfc_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STAY_TIME   = 3'd0,
        CFG_FADE_TIME   = 3'd1,
        CFG_START_COLOR = 3'd2,
        CFG_END_COLOR   = 3'd3,
        CFG_FADE_DEPTH  = 3'd4
    } cfg_idx_t;

    // Register reset values.
    localparam logic [23:0] STAY_TIME_RST   = 24'd0;
    localparam logic [23:0] FADE_TIME_RST   = 24'd1000;
    localparam logic [31:0] START_COLOR_RST = 32'hFFFF_FFFF;
    localparam logic [31:0] END_COLOR_RST   = 32'h0000_0000;
    localparam logic [22:0] FADE_DEPTH_RST  = 23'd256;

    // Stream widths.
    localparam int unsigned S_TDATA_W = 136;
    localparam int unsigned M_TDATA_W = 56;
    localparam int unsigned CFG_DATA_W = 32;

    // Fixed-point constants: one in Q1.16, one half in Q.16, and the
    // 99/100 threshold above which the depth ratio is forced to one.
    localparam logic [16:0] DEPTH_ONE = 17'h1_0000;
    localparam logic [15:0] HALF_Q16  = 16'h8000;
    localparam logic [6:0]  RATIO_NUM = 7'd100;
    localparam logic [6:0]  RATIO_DEN = 7'd99;
    localparam logic [7:0]  CHAN_MAX  = 8'd255;

    // Color channels and pipeline layout.
    localparam int unsigned NCH         = 4;
    localparam int unsigned NDIV_STAGES = 17;
    localparam int unsigned ADIV_STAGES = 8;
    localparam int unsigned ST_ADIV_END = 16;
    localparam int unsigned ST_ACOL     = 17;
    localparam int unsigned ST_DEP      = 20;
    localparam int unsigned ST_NCOL     = 21;
    localparam int unsigned ST_OUT      = 22;

    // Age path control carried alongside the color math.
    typedef struct packed {
        logic        win;
        logic        expired;
        logic [16:0] dfin;
    } age_ctl_t;

    // Finished age result waiting for the output stage.
    typedef struct packed {
        age_ctl_t          ctl;
        logic [3:0][7:0]   color;
    } age_res_t;

endpackage

// ===== hw/rtl/decal_vertex_fade_color.sv =====
// ----------------------------------------------------------------------------
// Decal vertex fade color
// Colors one decal vertex per transfer: depth fade for new vertices, timed
// start-to-end color blend for aging vertices.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_ channel (s_tvalid, s_tready, s_tdata, s_tuser) and
// results leave on the m_ channel; a transfer happens on a rising clk edge
// with tvalid and tready both high. s_tuser is the action: high colors a new
// vertex, low ages an existing one. m_tuser is the recoloured flag.
// Registers are written on the cfg channel, which is always ready; they must
// only be written while no item is in flight.
// Every item, of either action, runs through the same 22-stage pipeline,
// with results offered on m_tvalid from its last stage; unless stalled, one
// item can be taken in every cycle. The depth is set by the 17-step ratio
// divider of the new-vertex path; the age path uses 8-step dividers per
// channel and waits out the remaining stages so results leave in order.
// When the receiver stalls with a result held in the output register, the
// whole pipeline freezes and s_tready drops in the same cycle; nothing is
// dropped or repeated. Reset (rst_n low, asynchronous) empties the pipeline
// and returns the registers to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decal_vertex_fade_color_macros.svh"

module decal_vertex_fade_color
    import dvfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_time[31:0], start_time[63:32], depth_fade_in[80:64],
    // dist_front[104:81], dist_back[128:105], zero fill above
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24], expired[32],
    // depth_fade_out[49:33], zero fill above
    output logic [M_TDATA_W-1:0]  m_tdata,
    // recoloured
    output logic                  m_tuser,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. The port never pushes back.
    // ------------------------------------------------------------------
    logic [23:0] stay_time_reg;
    logic [23:0] fade_time_reg;
    logic [31:0] start_color_reg;
    logic [31:0] end_color_reg;
    logic [22:0] fade_depth_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stay_time_reg   <= STAY_TIME_RST;
            fade_time_reg   <= FADE_TIME_RST;
            start_color_reg <= START_COLOR_RST;
            end_color_reg   <= END_COLOR_RST;
            fade_depth_reg  <= FADE_DEPTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STAY_TIME:   stay_time_reg   <= cfg_data[23:0];
                CFG_FADE_TIME:   fade_time_reg   <= cfg_data[23:0];
                CFG_START_COLOR: start_color_reg <= cfg_data[31:0];
                CFG_END_COLOR:   end_color_reg   <= cfg_data[31:0];
                CFG_FADE_DEPTH:  fade_depth_reg  <= cfg_data[22:0];
                default:         ;
            endcase
        end
    end

    // Quantities derived from the registers. The user must keep them static
    // while items are in flight, which the block does not enforce; every stage reads them directly.
    logic [3:0][7:0] start_ch;
    logic [3:0][7:0] end_ch;
    logic [22:0]     fd_eff;
    logic [23:0]     div_d;
    logic [24:0]     max_time;

    assign start_ch = start_color_reg;
    assign end_ch   = end_color_reg;
    // A fade depth of zero behaves as the smallest step.
    assign fd_eff   = (fade_depth_reg == '0) ? 23'd1 : fade_depth_reg;
    assign div_d    = {fd_eff, 1'b0};
    assign max_time = {1'b0, stay_time_reg} + {1'b0, fade_time_reg};

    // ------------------------------------------------------------------
    // Pipeline control. Stage ST_OUT is the output register; the whole
    // pipe advances whenever that register is empty or being drained.
    // ------------------------------------------------------------------
    logic [ST_OUT:1]  vld_reg;
    logic [ST_NCOL:1] act_reg;
    logic             ce;

    assign ce       = !vld_reg[ST_OUT] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[ST_OUT-1:1], s_tvalid};
        end
    end

    // Input fields.
    logic [31:0] in_now;
    logic [31:0] in_start;
    logic [16:0] in_dfin;
    logic [23:0] in_front;
    logic [23:0] in_back;

    assign in_now   = s_tdata[31:0];
    assign in_start = s_tdata[63:32];
    assign in_dfin  = s_tdata[80:64];
    assign in_front = s_tdata[104:81];
    assign in_back  = s_tdata[128:105];

    // ------------------------------------------------------------------
    // New-vertex path, stages 1 and 2: pick the plane distance, form the
    // ratio numerator and test the 0.99 threshold.
    // ------------------------------------------------------------------
    logic        front_le0;
    logic        back_le0;
    logic [23:0] n1_mag_next;
    logic        n1_none_next;
    logic [23:0] n1_mag_reg;
    logic        n1_none_reg;

    assign front_le0    = in_front[23] || (in_front == '0);
    assign back_le0     = in_back[23] || (in_back == '0);
    // Magnitude of a non-positive distance; the most negative value maps
    // to 2^23, which still fits unsigned.
    assign n1_mag_next  = front_le0 ? (24'd0 - in_front) : (24'd0 - in_back);
    assign n1_none_next = !front_le0 && !back_le0;

    logic        n2_over_next;
    logic [40:0] n2_num_next;
    logic        n2_over_reg;
    logic        n2_none_reg;
    logic [40:0] n2_num_reg;

    assign n2_over_next = (31'(n1_mag_reg) * 31'(RATIO_NUM)) > (31'(fd_eff) * 31'(RATIO_DEN));
    // (mag * 2^17 + fd) / (2 fd) is the ratio in Q.16 rounded half up.
    assign n2_num_next  = {n1_mag_reg, 17'b0} + 41'(fd_eff);

    // ------------------------------------------------------------------
    // New-vertex ratio divider: one restoring step per stage, quotient bit
    // 16 first. The quotient stays below 2^16 whenever the ratio is used.
    // ------------------------------------------------------------------
    logic [40:0]            ndiv_rem_in   [1:NDIV_STAGES];
    logic [16:0]            ndiv_quo_in   [1:NDIV_STAGES];
    logic [40:0]            ndiv_sub      [1:NDIV_STAGES];
    logic                   ndiv_ge       [1:NDIV_STAGES];
    logic [40:0]            ndiv_rem_next [1:NDIV_STAGES];
    logic [16:0]            ndiv_quo_next [1:NDIV_STAGES];
    logic [40:0]            ndiv_rem_reg  [1:NDIV_STAGES];
    logic [16:0]            ndiv_quo_reg  [1:NDIV_STAGES];
    logic [NDIV_STAGES:1]   ndiv_over_reg;
    logic [NDIV_STAGES:1]   ndiv_none_reg;

    always_comb
    begin
        ndiv_rem_in[1] = n2_num_reg;
        ndiv_quo_in[1] = '0;
        for (int j = 2; j <= NDIV_STAGES; j++)
        begin
            ndiv_rem_in[j] = ndiv_rem_reg[j-1];
            ndiv_quo_in[j] = ndiv_quo_reg[j-1];
        end
        for (int j = 1; j <= NDIV_STAGES; j++)
        begin
            ndiv_sub[j]      = 41'(div_d) << (NDIV_STAGES - j);
            ndiv_ge[j]       = ndiv_rem_in[j] >= ndiv_sub[j];
            ndiv_rem_next[j] = ndiv_ge[j] ? (ndiv_rem_in[j] - ndiv_sub[j]) : ndiv_rem_in[j];
            ndiv_quo_next[j] = ndiv_quo_in[j]
                             | (ndiv_ge[j] ? (17'd1 << (NDIV_STAGES - j)) : 17'd0);
        end
    end

    // Stage ST_DEP: depth fade, then stage ST_NCOL: scaled start color.
    logic [16:0]     n_dep_next;
    logic [16:0]     n_dep_reg;
    logic [24:0]     n_prod [NCH];
    logic [3:0][7:0] n_col_next;
    logic [3:0][7:0] n_col_reg;
    logic [16:0]     n_dfo_reg;

    // With both distances in front of their planes the threshold test saw
    // no real magnitude, so that case takes priority.
    always_comb
    begin
        if (ndiv_none_reg[NDIV_STAGES])
        begin
            n_dep_next = DEPTH_ONE;
        end
        else if (ndiv_over_reg[NDIV_STAGES])
        begin
            n_dep_next = '0;
        end
        else
        begin
            n_dep_next = DEPTH_ONE - ndiv_quo_reg[NDIV_STAGES];
        end
    end

    // A byte times a fade of at most one plus one half stays within 24 bits.
    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            n_prod[k]     = 25'(start_ch[k]) * 25'(n_dep_reg) + 25'(HALF_Q16);
            n_col_next[k] = n_prod[k][23:16];
        end
    end

    // ------------------------------------------------------------------
    // Age path. Stage 1 takes the age, stage 2 the fade window, stage 3
    // the blend weights, stages 4 to 6 the products, stage 7 the rounding
    // bias, stage 8 the saturation test, stages 9 to 16 the divide by the
    // fade time and stage 17 the final channel bytes.
    // ------------------------------------------------------------------
    logic [31:0]        a1_age_reg;
    logic [16:0]        a1_dfin_reg;
    logic signed [32:0] age_s;
    logic signed [32:0] stay_s;
    logic signed [32:0] max_s;
    age_ctl_t           a2_ctl_next;
    logic [23:0]        a2_t_next;
    logic [23:0]        a2_t_reg;
    age_ctl_t           actl_reg [2:ST_ADIV_END];

    // The age wraps as a 32-bit difference and is then compared signed.
    assign age_s  = $signed({a1_age_reg[31], a1_age_reg});
    assign stay_s = $signed({9'b0, stay_time_reg});
    assign max_s  = $signed({8'b0, max_time});

    assign a2_ctl_next.win     = (age_s > stay_s) && (age_s <= max_s);
    assign a2_ctl_next.expired = age_s >= max_s;
    assign a2_ctl_next.dfin    = a1_dfin_reg;
    // Inside the window the time into the fade is below 2^24.
    assign a2_t_next           = a1_age_reg[23:0] - stay_time_reg;

    logic [23:0]        a3_t_reg;
    logic [23:0]        a3_ftmt_reg;
    logic [31:0]        a4_p_reg   [NCH];
    logic [31:0]        a4_q_reg   [NCH];
    logic [31:0]        a5_sum_reg [NCH];
    logic [48:0]        a6_prod_reg [NCH];
    logic [49:0]        a7_bias    [NCH];
    logic [33:0]        a7_y_reg   [NCH];
    logic [NCH-1:0]     a8_sat_next;
    logic [NCH-1:0]     a8_sat_reg;
    logic [31:0]        a8_rem_reg [NCH];

    // Rounding: (2 num + den) / (2 den) with den = fade_time * 2^16 is
    // floor((num + fade_time * 2^15) / 2^16) / fade_time.
    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            a7_bias[k]     = 50'(a6_prod_reg[k]) + 50'({fade_time_reg, 15'b0});
            a8_sat_next[k] = a7_y_reg[k] >= 34'({fade_time_reg, 8'b0});
        end
    end

    // Per-channel divider by the fade time, quotient bit 7 first. Past the
    // saturation test the dividend is below fade_time * 256.
    logic [31:0]          adiv_rem_in   [1:ADIV_STAGES][NCH];
    logic [7:0]           adiv_quo_in   [1:ADIV_STAGES][NCH];
    logic [31:0]          adiv_sub      [1:ADIV_STAGES];
    logic                 adiv_ge       [1:ADIV_STAGES][NCH];
    logic [31:0]          adiv_rem_next [1:ADIV_STAGES][NCH];
    logic [7:0]           adiv_quo_next [1:ADIV_STAGES][NCH];
    logic [31:0]          adiv_rem_reg  [1:ADIV_STAGES][NCH];
    logic [7:0]           adiv_quo_reg  [1:ADIV_STAGES][NCH];
    logic [NCH-1:0]       adiv_sat_reg  [1:ADIV_STAGES];

    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            adiv_rem_in[1][k] = a8_rem_reg[k];
            adiv_quo_in[1][k] = '0;
            for (int j = 2; j <= ADIV_STAGES; j++)
            begin
                adiv_rem_in[j][k] = adiv_rem_reg[j-1][k];
                adiv_quo_in[j][k] = adiv_quo_reg[j-1][k];
            end
        end
        for (int j = 1; j <= ADIV_STAGES; j++)
        begin
            adiv_sub[j] = 32'(fade_time_reg) << (ADIV_STAGES - j);
            for (int k = 0; k < NCH; k++)
            begin
                adiv_ge[j][k]       = adiv_rem_in[j][k] >= adiv_sub[j];
                adiv_rem_next[j][k] = adiv_ge[j][k] ? (adiv_rem_in[j][k] - adiv_sub[j])
                                                    : adiv_rem_in[j][k];
                adiv_quo_next[j][k] = adiv_quo_in[j][k]
                                    | (adiv_ge[j][k] ? (8'd1 << (ADIV_STAGES - j)) : 8'd0);
            end
        end
    end

    // Stage ST_ACOL: channel bytes, zero outside the fade window.
    age_res_t a_res_next;
    age_res_t ares_reg [ST_ACOL:ST_NCOL];

    always_comb
    begin
        a_res_next.ctl = actl_reg[ST_ADIV_END];
        for (int k = 0; k < NCH; k++)
        begin
            if (!actl_reg[ST_ADIV_END].win)
            begin
                a_res_next.color[k] = '0;
            end
            else if (adiv_sat_reg[ADIV_STAGES][k])
            begin
                a_res_next.color[k] = CHAN_MAX;
            end
            else
            begin
                a_res_next.color[k] = adiv_quo_reg[ADIV_STAGES][k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: choose the finished result by action.
    // ------------------------------------------------------------------
    logic [3:0][7:0] out_color_next;
    logic            out_recol_next;
    logic            out_exp_next;
    logic [16:0]     out_dfo_next;
    logic [3:0][7:0] out_color_reg;
    logic            out_recol_reg;
    logic            out_exp_reg;
    logic [16:0]     out_dfo_reg;

    always_comb
    begin
        if (act_reg[ST_NCOL])
        begin
            out_color_next = n_col_reg;
            out_recol_next = 1'b1;
            out_exp_next   = 1'b0;
            out_dfo_next   = n_dfo_reg;
        end
        else
        begin
            out_color_next = ares_reg[ST_NCOL].color;
            out_recol_next = ares_reg[ST_NCOL].ctl.win;
            out_exp_next   = ares_reg[ST_NCOL].ctl.expired;
            out_dfo_next   = ares_reg[ST_NCOL].ctl.dfin;
        end
    end

    assign m_tdata = {6'b0, out_dfo_reg, out_exp_reg, out_color_reg};
    assign m_tuser = out_recol_reg;

    // ------------------------------------------------------------------
    // Payload registers, all held while the pipe is frozen.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            act_reg <= {act_reg[ST_NCOL-1:1], s_tuser};

            // New-vertex path.
            n1_mag_reg    <= n1_mag_next;
            n1_none_reg   <= n1_none_next;
            n2_over_reg   <= n2_over_next;
            n2_none_reg   <= n1_none_reg;
            n2_num_reg    <= n2_num_next;
            for (int j = 1; j <= NDIV_STAGES; j++)
            begin
                ndiv_rem_reg[j] <= ndiv_rem_next[j];
                ndiv_quo_reg[j] <= ndiv_quo_next[j];
            end
            ndiv_over_reg <= {ndiv_over_reg[NDIV_STAGES-1:1], n2_over_reg};
            ndiv_none_reg <= {ndiv_none_reg[NDIV_STAGES-1:1], n2_none_reg};
            n_dep_reg     <= n_dep_next;
            n_dfo_reg     <= n_dep_reg;
            n_col_reg     <= n_col_next;

            // Age path.
            a1_age_reg  <= in_now - in_start;
            a1_dfin_reg <= in_dfin;
            a2_t_reg    <= a2_t_next;
            actl_reg[2] <= a2_ctl_next;
            for (int s = 3; s <= ST_ADIV_END; s++)
            begin
                actl_reg[s] <= actl_reg[s-1];
            end
            a3_t_reg    <= a2_t_reg;
            a3_ftmt_reg <= fade_time_reg - a2_t_reg;
            for (int k = 0; k < NCH; k++)
            begin
                a4_p_reg[k]    <= 32'(start_ch[k]) * 32'(a3_ftmt_reg);
                a4_q_reg[k]    <= 32'(end_ch[k]) * 32'(a3_t_reg);
                a5_sum_reg[k]  <= a4_p_reg[k] + a4_q_reg[k];
                a6_prod_reg[k] <= 49'(a5_sum_reg[k]) * 49'(actl_reg[5].dfin);
                a7_y_reg[k]    <= a7_bias[k][49:16];
                a8_rem_reg[k]  <= a7_y_reg[k][31:0];
                for (int j = 1; j <= ADIV_STAGES; j++)
                begin
                    adiv_rem_reg[j][k] <= adiv_rem_next[j][k];
                    adiv_quo_reg[j][k] <= adiv_quo_next[j][k];
                end
            end
            a8_sat_reg      <= a8_sat_next;
            adiv_sat_reg[1] <= a8_sat_reg;
            for (int j = 2; j <= ADIV_STAGES; j++)
            begin
                adiv_sat_reg[j] <= adiv_sat_reg[j-1];
            end
            ares_reg[ST_ACOL] <= a_res_next;
            for (int s = ST_ACOL + 1; s <= ST_NCOL; s++)
            begin
                ares_reg[s] <= ares_reg[s-1];
            end

            // Output register.
            out_color_reg <= out_color_next;
            out_recol_reg <= out_recol_next;
            out_exp_reg   <= out_exp_next;
            out_dfo_reg   <= out_dfo_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A result that carries no new color shows all channels at zero.
    `DVFC_ASSERT_IMPL(a_blank_when_not_recoloured, m_tvalid && !m_tuser, m_tdata[31:0] == 32'd0, "color bytes set on a result that is not recoloured")

    // A new vertex reaching the output stage is recoloured and never expired.
    `DVFC_ASSERT_NEXT(a_new_vertex_result, ce && vld_reg[ST_NCOL] && act_reg[ST_NCOL], m_tvalid && m_tuser && !m_tdata[32], "new vertex result lost its flags")

    // A ratio that is used leaves the divider below one.
    `DVFC_ASSERT_IMPL(a_ratio_below_one, vld_reg[ST_DEP-1] && act_reg[ST_DEP-1] && !ndiv_over_reg[NDIV_STAGES] && !ndiv_none_reg[NDIV_STAGES], !ndiv_quo_reg[NDIV_STAGES][16], "depth ratio quotient overflowed")

endmodule
